// ===== sv/bursol_pkg.sv =====
`default_nettype none
package bursol_pkg;

    // Storage depth and arithmetic widths.
    localparam int MAX_CELLS_DEF = 1024;
    localparam int DIV_W         = 56;
    localparam int DSR_W         = 32;
    localparam int XW            = 52;
    localparam int FW            = 42;

    localparam logic [30:0] TIME_MAX   = 31'h7FFF_FFFF;
    localparam logic [15:0] STEP_LIMIT = 16'hFFFF;
    localparam logic [24:0] ONE_Q      = 25'h100_0000;
    localparam logic [30:0] HALF_Q     = 31'h0080_0000;

    // Request kinds carried in tuser.
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_RUN   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_ZERO_SPEED = 2'd1;
    localparam logic [1:0] STAT_BAD_INDEX  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CELLS = 3'd0;
    localparam logic [2:0] CFG_DX    = 3'd1;
    localparam logic [2:0] CFG_LEFT  = 3'd2;
    localparam logic [2:0] CFG_TEND  = 3'd3;
    localparam logic [2:0] CFG_CFL   = 3'd4;

    localparam logic [9:0]  RST_CELLS = 10'd100;
    localparam logic [30:0] RST_DX    = 31'd503316;
    localparam logic [31:0] RST_LEFT  = 32'hFF00_0000;
    localparam logic [30:0] RST_TEND  = 31'd8388608;
    localparam logic [24:0] RST_CFL   = 25'd8388608;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ_DATA,
        S_RESP,
        S_CHECK,
        S_SCAN,
        S_SCAN_LAST,
        S_VCHK,
        S_DT_START,
        S_DT_WAIT,
        S_R_START,
        S_R_WAIT,
        S_SW_START,
        S_SW_LOAD,
        S_FX1,
        S_FX2,
        S_FX3,
        S_FX4,
        S_DIFF,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_GH_T,
        S_GH_X,
        S_EX,
        S_EX_WAIT
    } t_state;

endpackage
`default_nettype wire

// ===== sv/bursol_ram.sv =====
`default_nettype none
module bursol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== sv/bursol_div.sv =====
`default_nettype none
module bursol_div import bursol_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [DSR_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [DIV_W-1:0] o_quot
);

    localparam int CW = $clog2(DIV_W + 1);

    logic [DSR_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DSR_W-1:0] r_dsr, n_dsr;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [DSR_W:0]   w_trial;
    logic [DSR_W:0]   w_diff;

    // Restoring division, one quotient bit per cycle, MSB first.
    always_comb begin
        w_trial = {r_rem, r_quo[DIV_W-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dsr   = r_dsr;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem = '0;
            n_quo = i_dividend;
            n_dsr = i_divisor;
            n_cnt = CW'(DIV_W);
        end else if (r_cnt != '0) begin
            if (!w_diff[DSR_W]) begin
                n_rem = w_diff[DSR_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[DSR_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt  = r_cnt - CW'(1);
            n_done = (r_cnt == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
`default_nettype wire

// ===== sv/burgers_rusanov_solver.sv =====
// 1D Burgers solver with Rusanov flux, Q8.24 fixed point, one cell store in RAM.
// Input beats (s_axis): tuser holds the request kind (write, run, read); tdata holds
// the cell index and the value to write. Every input beat returns exactly one output
// beat (m_axis) with the read value, simulated time, step count and status.
// The block takes one request at a time: tready is high only while it is idle.
// A write goes straight to the response state; a read first latches the RAM data.
// A run repeats time steps until the simulated time reaches end_time, the step
// count reaches its limit or every cell is at rest. Each step scans for the max speed,
// finds dt and dt/dx in the shared one-bit-per-cycle divider, updates each interior cell
// on the shared 32x33 multiplier and writes the two ghost cells, using the divider where needed.
// A result is held in the output register until the receiver takes it; while it
// waits no new request is accepted. Reset restores the register defaults and clears
// time and step count; the cell store is not cleared and must be written before use.
// Configuration writes go through the cfg port and must happen while idle.
`default_nettype none
module burgers_rusanov_solver import bursol_pkg::*; #(
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,  // cell_index[9:0], cell_value[41:10]
    input  wire logic [1:0]  i_s_axis_tuser,  // req_type[1:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // read_value[31:0], time_now[62:32], step_count[78:63], status[80:79]
    output logic [87:0]      o_m_axis_tdata
);

    localparam int AW = $clog2(MAX_CELLS);

    function automatic logic [31:0] f_abs(input logic [31:0] v);
        f_abs = v[31] ? (~v + 32'd1) : v;
    endfunction

    t_state r_state, n_state;

    logic [9:0]  r_cells;
    logic [30:0] r_dx;
    logic [31:0] r_left;
    logic [30:0] r_tend;
    logic [24:0] r_cfl;

    logic [31:0]   r_rd_val, n_rd_val;
    logic [1:0]    r_status, n_status;
    logic [30:0]   r_sim, n_sim;
    logic [15:0]   r_steps, n_steps;
    logic [AW-1:0] r_cnt, n_cnt;
    logic          r_pend;
    logic [31:0]   r_vmax, n_vmax;
    logic [30:0]   r_dt, n_dt;
    logic [55:0]   r_r, n_r;
    logic [31:0]   r_b, n_b;
    logic [31:0]   r_c, n_c;
    logic [AW-1:0] r_i, n_i;
    logic          r_init, n_init;
    logic [37:0]   r_fa, n_fa;
    logic [37:0]   r_hs, n_hs;
    logic          r_tneg, n_tneg;
    logic [FW-1:0] r_flux, n_flux;
    logic [FW-1:0] r_fl, n_fl;
    logic [FW-2:0] r_dmag, n_dmag;
    logic          r_dneg, n_dneg;
    logic [56:0]   r_acc, n_acc;
    logic          r_sat, n_sat;
    logic [XW-1:0] r_xr, n_xr;
    logic [XW-1:0] r_x, n_x;
    logic          r_gsel, n_gsel;
    logic [64:0]   r_prod;

    logic [AW-1:0] w_n, w_np1;
    logic [30:0]   w_dx;
    logic [1:0]    w_in_req;
    logic [9:0]    w_in_idx;
    logic [31:0]   w_in_val;
    logic          w_idx_bad;
    logic          w_accept;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [31:0]   w_wdata, w_rdata;

    logic [31:0]   w_mul_a;
    logic [32:0]   w_mul_b;

    logic             w_div_start, w_div_done;
    logic [DIV_W-1:0] w_div_dividend, w_div_quot;
    logic [DSR_W-1:0] w_div_divisor;

    logic [31:0]   w_abs_rd, w_ab, w_ac, w_vm;
    logic [32:0]   w_cb, w_cb_abs;
    logic [38:0]   w_hsum;
    logic [FW-1:0] w_term, w_term_s, w_flux, w_diff;
    logic [57:0]   w_acc_sum;
    logic [32:0]   w_q;
    logic [34:0]   w_qs, w_v;
    logic [31:0]   w_vcl, w_new;
    logic          w_sat_all;
    logic [30:0]   w_dt_raw;
    logic [31:0]   w_tsum;
    logic [30:0]   w_half;
    logic [24:0]   w_omx;
    logic          w_run_go;
    logic          w_ex_div;
    logic [31:0]   w_ex_val;
    logic          w_ghost_wr;

    // Effective cell count and cell width.
    assign w_n   = (32'(r_cells) > 32'(MAX_CELLS - 2)) ? AW'(MAX_CELLS - 2) : AW'(r_cells);
    assign w_np1 = w_n + AW'(1);
    assign w_dx  = (r_dx == '0) ? 31'd1 : r_dx;

    assign w_in_req  = i_s_axis_tuser;
    assign w_in_idx  = i_s_axis_tdata[9:0];
    assign w_in_val  = i_s_axis_tdata[41:10];
    assign w_idx_bad = 32'(w_in_idx) > (32'(w_n) + 32'd1);
    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_RESP);
    assign o_m_axis_tdata  = {7'b0, r_status, r_steps, r_sim, r_rd_val};

    // Flux pieces. The multiplier output is registered from its operands.
    assign w_abs_rd = f_abs(w_rdata);
    assign w_ab     = f_abs(r_b);
    assign w_ac     = f_abs(r_c);
    assign w_vm     = (w_ab > w_ac) ? w_ab : w_ac;
    assign w_cb     = {r_c[31], r_c} - {r_b[31], r_b};
    assign w_cb_abs = w_cb[32] ? (~w_cb + 33'd1) : w_cb;
    assign w_hsum   = {1'b0, r_fa} + {1'b0, r_prod[62:25]};
    assign w_term   = {3'b0, r_prod[63:25]};
    assign w_term_s = r_tneg ? (~w_term + FW'(1)) : w_term;
    assign w_flux   = {4'b0, r_hs} - w_term_s;
    assign w_diff   = r_fl - r_flux;

    // Scaled update: |diff| * r is summed from four partial products. Once the sum
    // reaches 2^57 the new value saturates whatever the old one is.
    assign w_acc_sum = {1'b0, r_acc} + {1'b0, r_prod[24:0], 32'b0};
    assign w_sat_all = r_sat || (r_prod != '0);
    assign w_q       = r_acc[56:24];
    assign w_qs      = r_dneg ? (~{2'b0, w_q} + 35'd1) : {2'b0, w_q};
    assign w_v       = {{3{r_b[31]}}, r_b} + w_qs;
    always_comb begin
        if (!w_v[34] && (w_v[33:31] != 3'b000)) begin
            w_vcl = 32'h7FFF_FFFF;
        end else if (w_v[34] && (w_v[33:31] != 3'b111)) begin
            w_vcl = 32'h8000_0000;
        end else begin
            w_vcl = w_v[31:0];
        end
    end
    assign w_new = w_sat_all ? (r_dneg ? 32'h8000_0000 : 32'h7FFF_FFFF) : w_vcl;

    assign w_dt_raw = (w_div_quot[55:31] != '0) ? TIME_MAX : w_div_quot[30:0];
    assign w_tsum   = {1'b0, r_sim} + {1'b0, r_dt};
    assign w_run_go = (r_sim < r_tend) && (r_steps != STEP_LIMIT);

    // Exact solution at a ghost coordinate.
    assign w_half = {1'b0, r_sim[30:1]} + HALF_Q;
    assign w_omx  = ONE_Q - r_x[24:0];
    always_comb begin
        w_ex_div = 1'b0;
        w_ex_val = '0;
        if (r_sim < {6'b0, ONE_Q}) begin
            if ($signed(r_x) < $signed({21'b0, r_sim})) begin
                w_ex_val = {7'b0, ONE_Q};
            end else if ($signed(r_x) > $signed({27'b0, ONE_Q})) begin
                w_ex_val = '0;
            end else begin
                w_ex_div = 1'b1;
            end
        end else if ($signed(r_x) < $signed({21'b0, w_half})) begin
            w_ex_val = {7'b0, ONE_Q};
        end
    end
    assign w_ghost_wr = ((r_state == S_EX) && !w_ex_div) ||
                        ((r_state == S_EX_WAIT) && w_div_done);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    if (w_in_req == REQ_RUN) begin
                        n_state = S_CHECK;
                    end else if ((w_in_req == REQ_READ) && !w_idx_bad) begin
                        n_state = S_READ_DATA;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_READ_DATA: n_state = S_RESP;
            S_RESP: begin
                if (i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            S_CHECK:     n_state = w_run_go ? S_SCAN : S_RESP;
            S_SCAN:      n_state = (r_cnt == w_np1) ? S_SCAN_LAST : S_SCAN;
            S_SCAN_LAST: n_state = S_VCHK;
            S_VCHK:      n_state = (r_vmax == '0) ? S_RESP : S_DT_START;
            S_DT_START:  n_state = S_DT_WAIT;
            S_DT_WAIT:   n_state = w_div_done ? S_R_START : S_DT_WAIT;
            S_R_START:   n_state = S_R_WAIT;
            S_R_WAIT:    n_state = w_div_done ? S_SW_START : S_R_WAIT;
            S_SW_START:  n_state = S_SW_LOAD;
            S_SW_LOAD:   n_state = S_FX1;
            S_FX1:       n_state = S_FX2;
            S_FX2:       n_state = S_FX3;
            S_FX3:       n_state = S_FX4;
            S_FX4: begin
                if (!r_init) begin
                    n_state = S_DIFF;
                end else if (w_n == '0) begin
                    n_state = S_GH_T;
                end else begin
                    n_state = S_FX1;
                end
            end
            S_DIFF:      n_state = S_M0;
            S_M0:        n_state = S_M1;
            S_M1:        n_state = S_M2;
            S_M2:        n_state = S_M3;
            S_M3:        n_state = S_M4;
            S_M4:        n_state = (r_i == w_n) ? S_GH_T : S_FX1;
            S_GH_T:      n_state = S_GH_X;
            S_GH_X:      n_state = S_EX;
            S_EX: begin
                if (w_ex_div) begin
                    n_state = S_EX_WAIT;
                end else begin
                    n_state = r_gsel ? S_CHECK : S_EX;
                end
            end
            S_EX_WAIT: begin
                if (w_div_done) begin
                    n_state = r_gsel ? S_CHECK : S_EX;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // Datapath, memory, multiplier and divider controls.
    always_comb begin
        n_rd_val = r_rd_val;
        n_status = r_status;
        n_sim    = r_sim;
        n_steps  = r_steps;
        n_cnt    = r_cnt;
        n_vmax   = r_vmax;
        n_dt     = r_dt;
        n_r      = r_r;
        n_b      = r_b;
        n_c      = r_c;
        n_i      = r_i;
        n_init   = r_init;
        n_fa     = r_fa;
        n_hs     = r_hs;
        n_tneg   = r_tneg;
        n_flux   = r_flux;
        n_fl     = r_fl;
        n_dmag   = r_dmag;
        n_dneg   = r_dneg;
        n_acc    = r_acc;
        n_sat    = r_sat;
        n_xr     = r_xr;
        n_x      = r_x;
        n_gsel   = r_gsel;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_wdata  = '0;
        w_raddr  = '0;
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_div_start    = 1'b0;
        w_div_dividend = '0;
        w_div_divisor  = '0;
        case (r_state)
            S_IDLE: begin
                w_raddr = AW'(w_in_idx);
                if (i_s_axis_tvalid) begin
                    n_rd_val = '0;
                    n_status = STAT_OK;
                    if (w_in_req == REQ_RUN) begin
                        n_sim   = '0;
                        n_steps = '0;
                    end else if ((w_in_req == REQ_WRITE) || (w_in_req == REQ_READ)) begin
                        if (w_idx_bad) begin
                            n_status = STAT_BAD_INDEX;
                        end else if (w_in_req == REQ_WRITE) begin
                            w_we    = 1'b1;
                            w_waddr = AW'(w_in_idx);
                            w_wdata = w_in_val;
                        end
                    end
                end
            end
            S_READ_DATA: n_rd_val = w_rdata;
            S_CHECK: begin
                n_vmax = '0;
                n_cnt  = '0;
            end
            S_SCAN: begin
                w_raddr = r_cnt;
                n_cnt   = r_cnt + AW'(1);
                if (r_pend && (w_abs_rd > r_vmax)) begin
                    n_vmax = w_abs_rd;
                end
            end
            S_SCAN_LAST: begin
                if (w_abs_rd > r_vmax) begin
                    n_vmax = w_abs_rd;
                end
            end
            S_VCHK: begin
                if (r_vmax == '0) begin
                    n_status = STAT_ZERO_SPEED;
                end
                w_mul_a = {1'b0, w_dx};
                w_mul_b = {8'b0, r_cfl};
            end
            S_DT_START: begin
                w_div_start    = 1'b1;
                w_div_dividend = r_prod[55:0];
                w_div_divisor  = r_vmax;
            end
            S_DT_WAIT: begin
                if (w_div_done) begin
                    n_dt = (w_dt_raw == '0) ? 31'd1 : w_dt_raw;
                end
            end
            S_R_START: begin
                w_div_start    = 1'b1;
                w_div_dividend = {1'b0, r_dt, 24'b0};
                w_div_divisor  = {1'b0, w_dx};
            end
            S_R_WAIT: begin
                if (w_div_done) begin
                    n_r = w_div_quot;
                end
            end
            S_SW_START: w_raddr = '0;
            S_SW_LOAD: begin
                n_b    = w_rdata;
                n_i    = '0;
                n_init = 1'b1;
            end
            S_FX1: begin
                w_raddr = r_i + AW'(1);
                w_mul_a = w_ab;
                w_mul_b = {1'b0, w_ab};
            end
            S_FX2: begin
                n_fa    = r_prod[62:25];
                n_c     = w_rdata;
                w_mul_a = w_abs_rd;
                w_mul_b = {1'b0, w_abs_rd};
            end
            S_FX3: begin
                n_hs    = w_hsum[38:1];
                n_tneg  = w_cb[32];
                w_mul_a = w_vm;
                w_mul_b = w_cb_abs;
            end
            S_FX4: begin
                n_flux = w_flux;
                if (r_init) begin
                    // Left edge flux of the first interior cell.
                    n_fl   = w_flux;
                    n_b    = r_c;
                    n_i    = AW'(1);
                    n_init = 1'b0;
                end
            end
            S_DIFF: begin
                n_dneg = w_diff[FW-1];
                n_dmag = w_diff[FW-1] ? (~w_diff[FW-2:0] + (FW-1)'(1)) : w_diff[FW-2:0];
            end
            S_M0: begin
                w_mul_a = r_dmag[31:0];
                w_mul_b = {1'b0, r_r[31:0]};
            end
            S_M1: begin
                n_acc   = r_prod[56:0];
                n_sat   = (r_prod[64:57] != '0);
                w_mul_a = r_dmag[31:0];
                w_mul_b = {9'b0, r_r[55:32]};
            end
            S_M2: begin
                n_acc   = w_acc_sum[56:0];
                n_sat   = r_sat || (r_prod[64:25] != '0) || w_acc_sum[57];
                w_mul_a = {23'b0, r_dmag[40:32]};
                w_mul_b = {1'b0, r_r[31:0]};
            end
            S_M3: begin
                n_acc   = w_acc_sum[56:0];
                n_sat   = r_sat || (r_prod[64:25] != '0) || w_acc_sum[57];
                w_mul_a = {23'b0, r_dmag[40:32]};
                w_mul_b = {9'b0, r_r[55:32]};
            end
            S_M4: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = w_new;
                n_fl    = r_flux;
                n_b     = r_c;
                n_i     = r_i + AW'(1);
            end
            S_GH_T: begin
                n_sim   = w_tsum[31] ? TIME_MAX : w_tsum[30:0];
                w_mul_a = 32'({w_n, 1'b1});
                w_mul_b = {2'b0, w_dx};
            end
            S_GH_X: begin
                n_xr   = {{(XW-32){r_left[31]}}, r_left} + {1'b0, r_prod[XW-1:1]};
                n_x    = {{(XW-32){r_left[31]}}, r_left} - {{(XW-30){1'b0}}, w_dx[30:1]};
                n_gsel = 1'b0;
            end
            S_EX: begin
                if (w_ex_div) begin
                    w_div_start    = 1'b1;
                    w_div_dividend = {7'b0, w_omx, 24'b0};
                    w_div_divisor  = {7'b0, ONE_Q - r_sim[24:0]};
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_gsel ? w_np1 : '0;
                    w_wdata = w_ex_val;
                end
            end
            S_EX_WAIT: begin
                if (w_div_done) begin
                    w_we    = 1'b1;
                    w_waddr = r_gsel ? w_np1 : '0;
                    w_wdata = w_div_quot[31:0];
                end
            end
            default: begin
            end
        endcase
        if (w_ghost_wr) begin
            if (r_gsel) begin
                n_steps = r_steps + 16'd1;
            end else begin
                n_x    = r_xr;
                n_gsel = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cells  <= RST_CELLS;
            r_dx     <= RST_DX;
            r_left   <= RST_LEFT;
            r_tend   <= RST_TEND;
            r_cfl    <= RST_CFL;
            r_sim    <= '0;
            r_steps  <= '0;
            r_status <= STAT_OK;
            r_rd_val <= '0;
            r_pend   <= 1'b0;
            r_init   <= 1'b0;
            r_gsel   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sim    <= n_sim;
            r_steps  <= n_steps;
            r_status <= n_status;
            r_rd_val <= n_rd_val;
            r_pend   <= (r_state == S_SCAN);
            r_init   <= n_init;
            r_gsel   <= n_gsel;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_CELLS: r_cells <= i_cfg_wdata[9:0];
                    CFG_DX:    r_dx    <= i_cfg_wdata[30:0];
                    CFG_LEFT:  r_left  <= i_cfg_wdata;
                    CFG_TEND:  r_tend  <= i_cfg_wdata[30:0];
                    CFG_CFL:   r_cfl   <= i_cfg_wdata[24:0];
                    default: begin
                    end
                endcase
            end
        end
        r_cnt  <= n_cnt;
        r_vmax <= n_vmax;
        r_dt   <= n_dt;
        r_r    <= n_r;
        r_b    <= n_b;
        r_c    <= n_c;
        r_i    <= n_i;
        r_fa   <= n_fa;
        r_hs   <= n_hs;
        r_tneg <= n_tneg;
        r_flux <= n_flux;
        r_fl   <= n_fl;
        r_dmag <= n_dmag;
        r_dneg <= n_dneg;
        r_acc  <= n_acc;
        r_sat  <= n_sat;
        r_xr   <= n_xr;
        r_x    <= n_x;
        r_prod <= {33'b0, w_mul_a} * {32'b0, w_mul_b};
    end

    bursol_ram #(
        .WIDTH (32),
        .DEPTH (MAX_CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bursol_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input and output sides active together");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_in_req == REQ_RUN)) |=> ((r_sim == '0) && (r_steps == '0)))
        else $error("run did not restart time and step count");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> ((r_state == S_DT_WAIT) || (r_state == S_R_WAIT) ||
                        (r_state == S_EX_WAIT)))
        else $error("divider finished outside a wait state");

    a_scan_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_status == STAT_OK))
        else $error("status set before a run finished");

endmodule
`default_nettype wire

// ===== tb/rusanov_checker.sv =====
`timescale 1ns / 100ps
module rusanov_checker import bursol_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [47:0] i_s_tdata,   // cell_index[9:0], cell_value[41:10]
    input  wire logic [1:0]  i_s_tuser,   // req_type[1:0]
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    // read_value[31:0], time_now[62:32], step_count[78:63], status[80:79]
    input  wire logic [87:0] i_m_tdata,
    output int               o_pending,
    output int               o_errors,
    output int               o_runs,
    output int               o_steps
);

    localparam longint ONE    = 64'sd16777216;
    localparam longint TMAX   = 64'sd2147483647;
    localparam longint I64MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic signed [31:0] read_value;
        logic [30:0]        time_now;
        logic [15:0]        step_count;
        logic [1:0]         status;
    } solver_result_t;

    solver_result_t want_results[$];

    logic [9:0]         cells_reg;
    logic [30:0]        dx_reg;
    logic signed [31:0] left_reg;
    logic [30:0]        tend_reg;
    logic [24:0]        cfl_reg;

    logic signed [31:0] cell_mem [0:1023];
    longint             sim_t;
    int unsigned        step_n;

    function automatic longint active_cells();
        return (cells_reg > 10'd1022) ? 1022 : longint'(cells_reg);
    endfunction

    function automatic longint width_q();
        return (dx_reg == 0) ? 1 : longint'(dx_reg);
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint flux(longint a, longint b);
        longint fa, fb, vm;
        fa = (a * a) / (2 * ONE);
        fb = (b * b) / (2 * ONE);
        vm = absl(a) > absl(b) ? absl(a) : absl(b);
        return (fa + fb) / 2 - (vm * (b - a)) / (2 * ONE);
    endfunction

    function automatic longint scale_sat(longint a, longint r);
        longint mag;
        if (a == 0 || r == 0) return 0;
        mag = absl(a);
        if (mag > I64MAX / r) return a < 0 ? -I64MAX : I64MAX;
        return a < 0 ? -(mag * r) : mag * r;
    endfunction

    function automatic longint exact_u(longint x, longint t);
        if (t < ONE) begin
            if (x < t) return ONE;
            if (x > ONE) return 0;
            return ((ONE - x) * ONE) / (ONE - t);
        end
        return (x < t / 2 + ONE / 2) ? ONE : 0;
    endfunction

    function automatic longint ghost_pos(longint i);
        return longint'(left_reg) + ((2 * i - 1) * width_q()) / 2;
    endfunction

    // One explicit time step; returns 1 when every cell is at rest.
    function automatic bit time_step();
        longint n, dx, vmax, dt, r, cur, prev, v;
        n = active_cells();
        dx = width_q();
        vmax = 0;
        for (longint i = 0; i <= n + 1; i++)
            if (absl(cell_mem[i]) > vmax) vmax = absl(cell_mem[i]);
        if (vmax == 0) return 1;
        dt = (longint'(cfl_reg) * dx) / vmax;
        if (dt > TMAX) dt = TMAX;
        if (dt == 0) dt = 1;
        r = (dt <<< 24) / dx;
        // The sweep is in place, so the left neighbor is kept from before its update.
        prev = cell_mem[0];
        for (longint i = 1; i <= n; i++) begin
            cur = cell_mem[i];
            v = cur + scale_sat(flux(prev, cur) - flux(cur, cell_mem[i + 1]), r) / ONE;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            prev = cur;
            cell_mem[i] = v[31:0];
        end
        sim_t += dt;
        if (sim_t > TMAX) sim_t = TMAX;
        cell_mem[0] = exact_u(ghost_pos(0), sim_t);
        cell_mem[n + 1] = exact_u(ghost_pos(n + 1), sim_t);
        return 0;
    endfunction

    function automatic solver_result_t solve_request(logic [1:0] req, logic [9:0] idx,
                                                     logic signed [31:0] val);
        solver_result_t res;
        res.read_value = 0;
        res.status = STAT_OK;
        if (req == REQ_WRITE || req == REQ_READ) begin
            if (longint'(idx) > active_cells() + 1)
                res.status = STAT_BAD_INDEX;
            else if (req == REQ_WRITE)
                cell_mem[idx] = val;
            else
                res.read_value = cell_mem[idx];
        end else if (req == REQ_RUN) begin
            o_runs++;
            sim_t = 0;
            step_n = 0;
            while (sim_t < longint'(tend_reg) && step_n < 65535) begin
                if (time_step()) begin
                    res.status = STAT_ZERO_SPEED;
                    break;
                end
                step_n++;
                o_steps++;
            end
        end
        res.time_now = sim_t[30:0];
        res.step_count = step_n[15:0];
        return res;
    endfunction

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_runs = 0;
        o_steps = 0;
        for (int i = 0; i < 1024; i++) cell_mem[i] = 0;
    end

    always @(posedge i_clk) begin
        solver_result_t got, exp_r;
        if (!i_rst_n) begin
            cells_reg = RST_CELLS;
            dx_reg = RST_DX;
            left_reg = RST_LEFT;
            tend_reg = RST_TEND;
            cfl_reg = RST_CFL;
            sim_t = 0;
            step_n = 0;
            want_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_CELLS: cells_reg = i_cfg_wdata[9:0];
                    CFG_DX:    dx_reg = i_cfg_wdata[30:0];
                    CFG_LEFT:  left_reg = i_cfg_wdata;
                    CFG_TEND:  tend_reg = i_cfg_wdata[30:0];
                    CFG_CFL:   cfl_reg = i_cfg_wdata[24:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.read_value = i_m_tdata[31:0];
                got.time_now = i_m_tdata[62:32];
                got.step_count = i_m_tdata[78:63];
                got.status = i_m_tdata[80:79];
                if (want_results.size() == 0) begin
                    $error("result beat with no request outstanding");
                    o_errors++;
                end else begin
                    exp_r = want_results.pop_front();
                    if (got.read_value !== exp_r.read_value) begin
                        $error("read_value expected %0d got %0d",
                               exp_r.read_value, got.read_value);
                        o_errors++;
                    end
                    if (got.time_now !== exp_r.time_now) begin
                        $error("time_now expected %0d got %0d", exp_r.time_now, got.time_now);
                        o_errors++;
                    end
                    if (got.step_count !== exp_r.step_count) begin
                        $error("step_count expected %0d got %0d",
                               exp_r.step_count, got.step_count);
                        o_errors++;
                    end
                    if (got.status !== exp_r.status) begin
                        $error("status expected %0d got %0d", exp_r.status, got.status);
                        o_errors++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                want_results.push_back(solve_request(i_s_tuser, i_s_tdata[9:0],
                                                     i_s_tdata[41:10]));
        end
        o_pending = want_results.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
    import bursol_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_wdata = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // cell_index[9:0], cell_value[41:10]
    logic [1:0]  s_tuser = '0;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 0;
    // read_value[31:0], time_now[62:32], step_count[78:63], status[80:79]
    logic [87:0] m_tdata;

    int  pending, errors, runs, steps;
    bit  no_gaps = 0;
    bit  long_hold = 0;
    int  sent = 0;
    int  n_cells = 100;

    burgers_rusanov_solver dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata)
    );

    rusanov_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser), .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .o_pending(pending), .o_errors(errors),
        .o_runs(runs), .o_steps(steps)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random back-pressure, with one long hold-off on request.
    initial begin
        int k;
        forever begin
            if (long_hold) begin
                k = 400;
                long_hold = 0;
            end else begin
                k = no_gaps ? 0 : $urandom_range(0, 12);
            end
            if (k > 0) begin
                m_tready <= 0;
                repeat (k) @(posedge i_clk);
            end
            m_tready <= 1;
            @(posedge i_clk);
            while (!(m_tvalid && m_tready)) @(posedge i_clk);
        end
    end

    task automatic send_req(logic [1:0] req, logic [9:0] idx, logic [31:0] val);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tuser <= req;
        s_tdata <= {6'd0, val, idx};
        @(posedge i_clk);
        while (!(s_tvalid && s_tready)) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Registers change only with the solver idle; the write enable is left high
    // between back-to-back writes and dropped by cfg_done.
    task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
        i_cfg_we <= 1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic cfg_done();
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'(int'($urandom_range(0, 33554432)) - 16777216);
            2: return $urandom_range(0, 1) ? 32'h0100_0000 : 32'h0;
            default: return 32'(int'($urandom_range(0, 4194304)) - 2097152);
        endcase
    endfunction

    // End time is kept to at most max_steps of the shortest possible steps.
    task automatic set_phase_cfg(int n, logic [30:0] dx, logic [24:0] cfl,
                                 logic [31:0] left, int max_steps);
        longint dtmin, tend;
        dtmin = (longint'(cfl) * longint'(dx == 0 ? 31'd1 : dx)) >>> 31;
        if (dtmin < 1) dtmin = 1;
        tend = longint'($urandom_range(0, 1000)) * dtmin * max_steps / 1000;
        if (tend > 64'sd2147483647) tend = 64'sd2147483647;
        n_cells = n;
        cfg_write(CFG_CELLS, n);
        cfg_write(CFG_DX, {1'b0, dx});
        cfg_write(CFG_LEFT, left);
        cfg_write(CFG_TEND, tend[31:0]);
        cfg_write(CFG_CFL, {7'd0, cfl});
        cfg_done();
    endtask

    initial begin
        logic [30:0] dx;
        logic [24:0] cfl;
        int          op, n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Reset geometry: an index just past the right ghost and a far read are refused; an unknown kind is sent too.
        send_req(REQ_WRITE, 10'd102, 32'h1234_5678);
        send_req(REQ_READ, 10'd1023, 32'h0);
        send_req(2'd3, 10'd5, 32'hFFFF_FFFF);
        drain();

        // A cell count too large for the store is capped, then every cell gets a value.
        no_gaps = 1;
        cfg_write(CFG_CELLS, 10'd1023);
        cfg_write(CFG_TEND, 32'd1);
        cfg_done();
        for (int i = 0; i < 1024; i++)
            send_req(REQ_WRITE, i[9:0], (i % 3 == 0) ? 32'h0100_0000 : rand_value());
        no_gaps = 0;
        send_req(REQ_WRITE, 10'd1023, 32'h8000_0000);
        send_req(REQ_WRITE, 10'd1, 32'h7FFF_FFFF);
        send_req(REQ_READ, 10'd1023, 32'h0);
        send_req(REQ_RUN, 10'd0, 32'h0);
        send_req(REQ_READ, 10'd1, 32'h0);
        drain();

        // Smallest grid: zero end time, all cells at rest, zero cell width, then the widest cell.
        cfg_write(CFG_CELLS, 10'd3);
        cfg_write(CFG_TEND, 32'd0);
        cfg_done();
        send_req(REQ_RUN, 10'd3, 32'h0);
        for (int i = 0; i < 5; i++) send_req(REQ_WRITE, i[9:0], 32'h0);
        drain();
        cfg_write(CFG_TEND, 32'h7FFF_FFFF);
        cfg_done();
        send_req(REQ_RUN, 10'd0, 32'h0);
        send_req(REQ_WRITE, 10'd2, 32'h0100_0000);
        drain();
        cfg_write(CFG_DX, 32'd0);
        cfg_write(CFG_TEND, 32'd3);
        cfg_write(CFG_CFL, 32'h0100_0000);
        cfg_write(CFG_LEFT, 32'h8000_0000);
        cfg_done();
        send_req(REQ_RUN, 10'd0, 32'h0);
        send_req(REQ_READ, 10'd4, 32'h0);
        send_req(REQ_WRITE, 10'd5, 32'h0);
        drain();
        set_phase_cfg(3, 31'h7FFF_FFFF, 25'h100_0000, 32'h7FFF_FFFF, 8);
        send_req(REQ_RUN, 10'd0, 32'h0);
        send_req(REQ_READ, 10'd0, 32'h0);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
            case ($urandom_range(0, 3))
                0: dx = $urandom;
                1: dx = 31'd503316;
                2: dx = $urandom_range(1, 4096);
                default: dx = $urandom_range(100000, 4000000);
            endcase
            cfl = ($urandom_range(0, 4) == 0) ? 25'd1 : $urandom_range(1, 16777216);
            set_phase_cfg(n, dx, cfl, $urandom, 12);
            no_gaps = (ph % 4 == 3);
            if (ph == 2) long_hold = 1;
            for (int it = 0; it < 80; it++) begin
                // At times a fresh profile is loaded; then a random run, write, read or bad request.
                if (it % 20 == 0 && $urandom_range(0, 3) != 0) begin
                    for (int i = 0; i <= n_cells + 1; i++)
                        send_req(REQ_WRITE, i[9:0], rand_value());
                end
                if (ph == 5 && it == 40) drain();
                op = $urandom_range(0, 99);
                if (op < 8)
                    send_req(REQ_RUN, $urandom, $urandom);
                else if (op < 45)
                    send_req(REQ_WRITE, $urandom_range(0, n_cells + 1), rand_value());
                else if (op < 85)
                    send_req(REQ_READ, $urandom_range(0, n_cells + 1), $urandom);
                else if (op < 95)
                    send_req($urandom_range(0, 1) ? REQ_WRITE : REQ_READ,
                             $urandom_range(n_cells + 2, 1023), $urandom);
                else
                    send_req(2'd3, $urandom, $urandom);
            end
            drain();
        end

        $display("Sent %0d requests over 12 random setups; %0d runs took %0d time steps.",
                 sent, runs, steps);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
